[sv/alq_pkg.sv]
// shared types and constants for the array linked list queue
// no dependencies; imported by alq_front, alq_back and the top level
package alq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int VALUE_W      = 32;

    // command codes on the input tuser
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_PRINT  = 2'd2;

    // status codes on the output tuser
    localparam logic [2:0] ST_INSERTED    = 3'd0;
    localparam logic [2:0] ST_FULL        = 3'd1;
    localparam logic [2:0] ST_DELETED     = 3'd2;
    localparam logic [2:0] ST_EMPTY_DEL   = 3'd3;
    localparam logic [2:0] ST_ELEMENT     = 3'd4;
    localparam logic [2:0] ST_EMPTY_PRINT = 3'd5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_PRINT  = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic signed [VALUE_W-1:0]  value;
    } op_item_t;

endpackage

[sv/alq_ram.sv]
// generic single write port ram with registered read
// no dependencies
module alq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/alq_front.sv]
// front end: accepts commands, drops the unused code, queues operations
// depends on alq_pkg
module alq_front
    import alq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic signed [VALUE_W-1:0] s_axis_tdata,   // item_value
    input  logic [1:0]                s_axis_tuser,   // cmd
    output logic                      q_valid,
    output op_item_t                  q_item,
    input  logic                      q_pop
);

    op_item_t    fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        cmd_ok;
    op_item_t    item_in;

    always_comb
    begin
        item_in.value = s_axis_tdata;
        item_in.kind  = OP_INSERT;
        cmd_ok        = 1'b1;
        unique case (s_axis_tuser)
            CMD_INSERT: item_in.kind = OP_INSERT;
            CMD_DELETE: item_in.kind = OP_DELETE;
            CMD_PRINT:  item_in.kind = OP_PRINT;
            default:    cmd_ok = 1'b0;
        endcase
    end

    assign s_axis_tready = (count_reg != 2'd2);
    // the unused command is taken and produces nothing
    assign push          = s_axis_tvalid && s_axis_tready && cmd_ok;
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

[sv/alq_back.sv]
// back end: runs queued operations on the entry store and drives the result register
// depends on alq_pkg and alq_ram
module alq_back
    import alq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  op_item_t                  q_item,
    output logic                      q_pop,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic signed [VALUE_W-1:0] m_axis_tdata,
    output logic [2:0]                m_axis_tuser,
    output logic                      m_axis_tlast
);

    localparam int IDXW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LINKW       = IDXW + 1;
    localparam int STEPW       = $clog2(CAPACITY + 1);
    localparam int PRINT_LIMIT = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    op_kind_t                  op_reg, op_next;
    logic [IDXW-1:0]           cur_reg, cur_next;
    logic [IDXW-1:0]           slot_reg, slot_next;
    logic [STEPW-1:0]          step_reg, step_next;
    logic [IDXW-1:0]           head_idx_reg, head_idx_next;
    logic                      head_valid_reg, head_valid_next;
    logic [STEPW-1:0]          next_free_reg, next_free_next;
    logic [2:0]                res_reg, res_next;

    logic                      m_valid_reg, m_valid_next;
    logic signed [VALUE_W-1:0] m_value_reg, m_value_next;
    logic [2:0]                m_status_reg, m_status_next;
    logic                      m_last_reg, m_last_next;

    logic                      out_free;
    logic                      emit;
    logic [2:0]                e_status;
    logic signed [VALUE_W-1:0] e_value;
    logic                      e_last;

    logic [IDXW-1:0]           rd_addr;
    logic [IDXW-1:0]           new_slot;
    logic                      val_we;
    logic [VALUE_W-1:0]        val_rdata;
    logic                      link_we;
    logic [IDXW-1:0]           link_waddr;
    logic [LINKW-1:0]          link_wdata;
    logic [LINKW-1:0]          link_rdata;
    logic                      link_vld;
    logic [IDXW-1:0]           link_idx;
    logic                      print_final;

    alq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_values (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (new_slot),
        .wr_data (q_item.value),
        .rd_addr (rd_addr),
        .rd_data (val_rdata)
    );

    // link word: top bit marks a following entry, low bits its index
    alq_ram #(
        .WIDTH (LINKW),
        .DEPTH (CAPACITY)
    ) u_links (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (rd_addr),
        .rd_data (link_rdata)
    );

    assign out_free    = !m_valid_reg || m_axis_tready;
    assign new_slot    = next_free_reg[IDXW-1:0];
    assign link_vld    = link_rdata[IDXW];
    assign link_idx    = link_rdata[IDXW-1:0];
    assign print_final = !link_vld || (step_reg == STEPW'(PRINT_LIMIT - 1));

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cur_next        = cur_reg;
        slot_next       = slot_reg;
        step_next       = step_reg;
        head_idx_next   = head_idx_reg;
        head_valid_next = head_valid_reg;
        next_free_next  = next_free_reg;
        res_next        = res_reg;
        q_pop           = 1'b0;
        val_we          = 1'b0;
        link_we         = 1'b0;
        link_waddr      = cur_reg;
        link_wdata      = '0;
        rd_addr         = cur_reg;
        emit            = 1'b0;
        e_status        = res_reg;
        e_value         = '0;
        e_last          = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = head_idx_reg;
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_item.kind;
                    step_next = '0;
                    cur_next  = head_idx_reg;
                    unique case (q_item.kind)
                        OP_INSERT:
                        begin
                            if (next_free_reg == STEPW'(CAPACITY))
                            begin
                                res_next   = ST_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                // new entry is the tail: no following entry
                                val_we         = 1'b1;
                                link_we        = 1'b1;
                                link_waddr     = new_slot;
                                link_wdata     = '0;
                                slot_next      = new_slot;
                                next_free_next = next_free_reg + STEPW'(1);
                                if (!head_valid_reg)
                                begin
                                    head_idx_next   = new_slot;
                                    head_valid_next = 1'b1;
                                    res_next        = ST_INSERTED;
                                    state_next      = S_RESP;
                                end
                                else
                                begin
                                    state_next = S_WALK;
                                end
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!head_valid_reg)
                            begin
                                res_next   = ST_EMPTY_DEL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        OP_PRINT:
                        begin
                            if (!head_valid_reg)
                            begin
                                res_next   = ST_EMPTY_PRINT;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (link_vld && (step_reg != STEPW'(CAPACITY)))
                        begin
                            cur_next  = link_idx;
                            rd_addr   = link_idx;
                            step_next = step_reg + STEPW'(1);
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = cur_reg;
                            link_wdata = {1'b1, slot_reg};
                            res_next   = ST_INSERTED;
                            state_next = S_RESP;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (out_free)
                        begin
                            emit            = 1'b1;
                            e_status        = ST_DELETED;
                            e_value         = val_rdata;
                            head_valid_next = link_vld;
                            head_idx_next   = link_vld ? link_idx : '0;
                            state_next      = S_IDLE;
                        end
                    end
                    OP_PRINT:
                    begin
                        if (out_free)
                        begin
                            emit     = 1'b1;
                            e_status = ST_ELEMENT;
                            e_value  = val_rdata;
                            e_last   = print_final;
                            if (print_final)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                cur_next  = link_idx;
                                rd_addr   = link_idx;
                                step_next = step_reg + STEPW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        if (emit)
        begin
            m_valid_next  = 1'b1;
            m_value_next  = e_value;
            m_status_next = e_status;
            m_last_next   = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_valid_reg <= 1'b0;
            head_idx_reg   <= '0;
            next_free_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            head_idx_reg   <= head_idx_next;
            next_free_reg  <= next_free_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cur_reg      <= cur_next;
        slot_reg     <= slot_next;
        step_reg     <= step_next;
        res_reg      <= res_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_value_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

[sv/array_linked_list_queue_core.sv]
// Queue kept as a singly linked list in a store of CAPACITY entries, each entry a
// 32-bit value plus a link. Commands arrive on the slave stream (tuser: 0 insert at
// tail, 1 delete from front, 2 print, 3 ignored); each command but the ignored one
// produces one or more results on the master stream, the final one with tlast.
// Entries are handed out in order and never recycled, so after CAPACITY inserts
// since reset every insert answers full. A two-entry command queue lets new
// commands be taken while the engine works. Insert walks from the head to the tail
// one link per cycle; print gives one element per cycle while the output is not
// stalled. The walk speed is set by the single read port of the link store. No
// clearing pass after reset.
//
// top level; depends on alq_pkg, alq_front, alq_back, alq_ram
module array_linked_list_queue_core
    import alq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic signed [VALUE_W-1:0] s_axis_tdata,   // [31:0] item_value
    input  logic [1:0]                s_axis_tuser,   // [1:0] cmd
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic signed [VALUE_W-1:0] m_axis_tdata,   // [31:0] out_value
    output logic [2:0]                m_axis_tuser,   // [2:0] status
    output logic                      m_axis_tlast
);

    logic     q_valid;
    op_item_t q_item;
    logic     q_pop;

    alq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    alq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // the engine never takes from an empty command queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("command popped from empty queue");

    // single-result statuses carry a zero value and close the command
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_INSERTED || m_axis_tuser == ST_FULL ||
                          m_axis_tuser == ST_EMPTY_DEL || m_axis_tuser == ST_EMPTY_PRINT)
        |-> (m_axis_tdata == '0) && m_axis_tlast)
        else $error("single result with value or without last");

    // a print that is not finished continues with list elements only
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && (m_axis_tuser == ST_ELEMENT) && !m_axis_tlast
        |=> !m_axis_tvalid || (m_axis_tuser == ST_ELEMENT))
        else $error("print interrupted by another result");

    // a newly raised result other than an element or a delete is the last of its command
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) && (m_axis_tuser != ST_ELEMENT) && (m_axis_tuser != ST_DELETED)
        |-> m_axis_tlast)
        else $error("final result without last");

endmodule
